>>> rtl/core/uktpc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and datapath functions for the UID keyed TEA page cipher.
// No dependencies; every other file in rtl/core but uktpc_channels imports this package.
package uktpc_pkg;

   localparam int TEA_ROUNDS_DEFAULT = 32;
   localparam int KEY_STAGES         = 5;

   localparam logic [31:0] TEA_DELTA = 32'h9E3779B9;

   // Constant pad words 2..5 (little-endian bytes of the fixed table), plain and with
   // the top byte forced to 0xaa, which is the last word of each key scramble.
   localparam logic [31:0] PAD_WORD [4] = '{
      32'he7e6d7d5, 32'hd8a83cba, 32'hcf684775, 32'haafee923
   };
   localparam logic [31:0] PAD_WORD_FORCED [4] = '{
      32'haae6d7d5, 32'haaa83cba, 32'haa684775, 32'haafee923
   };
   localparam logic [7:0] UID_PAD_BYTE = 8'hb7;

   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } uktpc_op_type;

   typedef struct packed {
      uktpc_op_type     opcode;
      logic [31:0]      v0;
      logic [31:0]      v1;
      logic [31:0]      acc;
      logic [3:0][31:0] key;
   } uktpc_key_stage_type;

   typedef struct packed {
      uktpc_op_type     opcode;
      logic [31:0]      v0;
      logic [31:0]      v1;
      logic [3:0][31:0] key;
   } uktpc_tea_type;

   typedef struct packed {
      logic [31:0] result_a;
      logic [31:0] result_b;
      logic [31:0] char_id;
      logic        id_match;
   } uktpc_rsp_type;

   function automatic logic [31:0] bswap32(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   // acc' = w + rotr(acc,25) + rotr(acc,10) - acc
   function automatic logic [31:0] key_step(input logic [31:0] acc, input logic [31:0] w);
      logic [31:0] r25;
      logic [31:0] r10;
      r25 = {acc[24:0], acc[31:25]};
      r10 = {acc[9:0], acc[31:10]};
      return w + r25 + r10 - acc;
   endfunction

   function automatic logic [31:0] tea_mix(input logic [31:0] v, input logic [31:0] sum,
                                           input logic [31:0] ka, input logic [31:0] kb);
      return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
   endfunction

   // One half of a TEA round; encrypt and decrypt run the halves in opposite word order.
   function automatic uktpc_tea_type tea_half(input uktpc_tea_type d, input logic second,
                                              input logic [31:0] sum_enc,
                                              input logic [31:0] sum_dec);
      uktpc_tea_type r;
      r = d;
      if (!second) begin
         if (d.opcode == OP_ENCRYPT) begin
            r.v0 = d.v0 + tea_mix(d.v1, sum_enc, d.key[0], d.key[1]);
         end else begin
            r.v1 = d.v1 - tea_mix(d.v0, sum_dec, d.key[2], d.key[3]);
         end
      end else begin
         if (d.opcode == OP_ENCRYPT) begin
            r.v1 = d.v1 + tea_mix(d.v0, sum_enc, d.key[2], d.key[3]);
         end else begin
            r.v0 = d.v0 - tea_mix(d.v1, sum_dec, d.key[0], d.key[1]);
         end
      end
      return r;
   endfunction

   function automatic uktpc_rsp_type finish(input uktpc_tea_type d);
      uktpc_rsp_type r;
      if (d.opcode == OP_ENCRYPT) begin
         r.result_a = bswap32(d.v0);
         r.result_b = bswap32(d.v1);
         r.char_id  = '0;
         r.id_match = 1'b0;
      end else begin
         r.result_a = d.v0;
         r.result_b = d.v1;
         r.id_match = (d.v0 == d.v1);
         r.char_id  = r.id_match ? d.v0 : '0;
      end
      return r;
   endfunction

endpackage

>>> rtl/core/uktpc_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response sides of the cipher.
// Standalone; widths are fixed by the item format.
interface uktpc_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [55:0] uid;
   logic [31:0] word_a;
   logic [31:0] word_b;

   modport source (output valid, output opcode, output uid, output word_a, output word_b,
                   input ready);
   modport sink   (input valid, input opcode, input uid, input word_a, input word_b,
                   output ready);
endinterface

interface uktpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_a;
   logic [31:0] result_b;
   logic [31:0] char_id;
   logic        id_match;

   modport source (output valid, output result_a, output result_b, output char_id,
                   output id_match, input ready);
   modport sink   (input valid, input result_a, input result_b, input char_id,
                   input id_match, output ready);
endinterface

>>> rtl/core/uktpc_key_sched.sv
`timescale 1ns / 1ps
// Five-stage key derivation: one rotate-add scramble step per stage, also loads the
// initial TEA words. Depends on uktpc_pkg.
module uktpc_key_sched import uktpc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic          opcode,
   input  logic [55:0]   uid,
   input  logic [31:0]   word_a,
   input  logic [31:0]   word_b,
   output logic          out_valid,
   output uktpc_tea_type out_data
);

   logic [KEY_STAGES-1:0] valid_ff;
   logic [KEY_STAGES-1:0] valid_in;
   uktpc_key_stage_type   stage_ff [KEY_STAGES];
   uktpc_key_stage_type   stage_in [KEY_STAGES];

   // First stage: acc after words 0 and 1 (acc after word 0 is word 0 itself).
   always_comb begin
      stage_in[0].opcode = uktpc_op_type'(opcode);
      stage_in[0].acc    = key_step(uid[31:0], {UID_PAD_BYTE, uid[55:32]});
      stage_in[0].key    = '0;
      if (opcode == OP_ENCRYPT) begin
         stage_in[0].v0 = word_a;
         stage_in[0].v1 = word_a;
      end else begin
         stage_in[0].v0 = bswap32(word_a);
         stage_in[0].v1 = bswap32(word_b);
      end
   end

   assign valid_in = {valid_ff[KEY_STAGES-2:0], in_valid};

   // Stage j takes word j+1; the forced variant closes key word j-1, the plain one
   // carries the shared prefix on.
   for (genvar j = 1; j < KEY_STAGES; j++) begin : g_step
      always_comb begin
         stage_in[j]          = stage_ff[j-1];
         stage_in[j].acc      = key_step(stage_ff[j-1].acc, PAD_WORD[j-1]);
         stage_in[j].key[j-1] = key_step(stage_ff[j-1].acc, PAD_WORD_FORCED[j-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < KEY_STAGES; i++) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   assign out_valid       = valid_ff[KEY_STAGES-1];
   assign out_data.opcode = stage_ff[KEY_STAGES-1].opcode;
   assign out_data.v0     = stage_ff[KEY_STAGES-1].v0;
   assign out_data.v1     = stage_ff[KEY_STAGES-1].v1;
   assign out_data.key    = stage_ff[KEY_STAGES-1].key;

endmodule

>>> rtl/core/uktpc_tea_pipe.sv
`timescale 1ns / 1ps
// Unrolled TEA datapath, one half round per register stage, encrypt or decrypt per item.
// Depends on uktpc_pkg.
module uktpc_tea_pipe import uktpc_pkg::*; #(
   parameter int TEA_ROUNDS = TEA_ROUNDS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  uktpc_tea_type in_data,
   output logic          out_valid,
   output uktpc_tea_type out_data
);

   localparam int STAGES = 2 * TEA_ROUNDS;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   uktpc_tea_type     stage_ff [STAGES];
   uktpc_tea_type     stage_in [STAGES];
   uktpc_tea_type     stage_src [STAGES];

   if (STAGES > 1) begin : g_vmulti
      assign valid_in = {valid_ff[STAGES-2:0], in_valid};
   end else begin : g_vsingle
      assign valid_in = in_valid;
   end

   for (genvar s = 0; s < STAGES; s++) begin : g_half
      localparam int          ROUND    = s / 2;
      localparam logic        SECOND   = (s % 2) == 1;
      localparam logic [63:0] SUM_ENC_W = 64'(TEA_DELTA) * 64'(ROUND + 1);
      localparam logic [63:0] SUM_DEC_W = 64'(TEA_DELTA) * 64'(TEA_ROUNDS - ROUND);
      localparam logic [31:0] SUM_ENC  = SUM_ENC_W[31:0];
      localparam logic [31:0] SUM_DEC  = SUM_DEC_W[31:0];

      if (s == 0) begin : g_first
         assign stage_src[s] = in_data;
      end else begin : g_next
         assign stage_src[s] = stage_ff[s-1];
      end

      assign stage_in[s] = tea_half(stage_src[s], SECOND, SUM_ENC, SUM_DEC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < STAGES; i++) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_data  = stage_ff[STAGES-1];

endmodule

>>> rtl/core/uktpc_skid.sv
`timescale 1ns / 1ps
// Two-entry output buffer: the pipeline keeps moving while one result waits.
// Depends on uktpc_pkg.
module uktpc_skid import uktpc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  uktpc_rsp_type push_data,
   input  logic          out_ready,
   output logic          out_valid,
   output uktpc_rsp_type out_data,
   output logic          room
);

   logic          main_valid_ff;
   logic          spare_valid_ff;
   uktpc_rsp_type main_ff;
   uktpc_rsp_type spare_ff;
   logic          pop;

   assign pop = main_valid_ff && out_ready;

   // push only arrives while the spare slot is free
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else if (spare_valid_ff) begin
         if (pop) begin
            spare_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_valid_ff <= 1'b1;
         end else begin
            spare_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (spare_valid_ff) begin
         if (pop) begin
            main_ff <= spare_ff;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_ff <= push_data;
         end else begin
            spare_ff <= push_data;
         end
      end
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign room      = !spare_valid_ff;

endmodule

>>> rtl/core/uid_keyed_tea_page_cipher.sv
`timescale 1ns / 1ps
// Top level of the UID keyed TEA page cipher: key schedule, TEA pipeline, output buffer.
// Depends on uktpc_pkg, uktpc_channels, uktpc_key_sched, uktpc_tea_pipe, uktpc_skid.

// Takes one request per clock while the output buffer has room, and returns one response
// per request, in order. Each request derives its 128-bit key from the UID in five
// pipeline stages, then runs 2*TEA_ROUNDS stages of half TEA rounds, and the response
// lands in a two-entry output buffer. The whole pipeline moves on a single enable that
// drops only while both output buffer entries are full, so the sustained rate is one
// item per cycle whenever the response side keeps up; req_ready is a register.
module uid_keyed_tea_page_cipher import uktpc_pkg::*; #(
   parameter int TEA_ROUNDS = TEA_ROUNDS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   uktpc_req_if.sink    req_chan,
   uktpc_rsp_if.source  rsp_chan
);

   logic          pipe_en;
   logic          key_valid;
   uktpc_tea_type key_data;
   logic          tea_valid;
   uktpc_tea_type tea_data;
   uktpc_rsp_type done_data;
   uktpc_rsp_type out_data;
   logic          out_valid;

   assign req_chan.ready = pipe_en;

   uktpc_key_sched u_key (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_chan.valid),
      .opcode    (req_chan.opcode),
      .uid       (req_chan.uid),
      .word_a    (req_chan.word_a),
      .word_b    (req_chan.word_b),
      .out_valid (key_valid),
      .out_data  (key_data)
   );

   uktpc_tea_pipe #(
      .TEA_ROUNDS (TEA_ROUNDS)
   ) u_tea (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (key_valid),
      .in_data   (key_data),
      .out_valid (tea_valid),
      .out_data  (tea_data)
   );

   assign done_data = finish(tea_data);

   uktpc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (tea_valid && pipe_en),
      .push_data (done_data),
      .out_ready (rsp_chan.ready),
      .out_valid (out_valid),
      .out_data  (out_data),
      .room      (pipe_en)
   );

   assign rsp_chan.valid    = out_valid;
   assign rsp_chan.result_a = out_data.result_a;
   assign rsp_chan.result_b = out_data.result_b;
   assign rsp_chan.char_id  = out_data.char_id;
   assign rsp_chan.id_match = out_data.id_match;

   a_match_fields: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_data.id_match |->
         out_data.char_id == out_data.result_a && out_data.result_a == out_data.result_b)
      else $error("id_match set but halves or char_id disagree");

   a_nomatch_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_data.id_match |-> out_data.char_id == '0)
      else $error("char_id nonzero without id_match");

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |-> out_valid)
      else $error("pipeline stalled with empty output buffer");

   a_pipe_holds: assert property (@(posedge clock) disable iff (reset)
      tea_valid && !pipe_en |=> tea_valid && $stable(tea_data))
      else $error("pipeline output changed during stall");

endmodule
